// ===== rtl/windowed_pixel_base64_encoder_defines.svh =====
// Assertion macros shared by the checker of the windowed base64 encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef WINDOWED_PIXEL_BASE64_ENCODER_DEFINES_SVH
`define WINDOWED_PIXEL_BASE64_ENCODER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define WPB64_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define WPB64_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// state right after a reset cycle
`define WPB64_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed: state after reset");

`endif

// ===== rtl/wpb64_pkg.sv =====
// Shared types, constants and the base64 symbol function of the encoder.
// Depends on nothing; imported by every module of the block.
package wpb64_pkg;

   localparam int CfgW    = 12;
   localparam int StepW   = 8;
   localparam int CsrIdxW = 3;
   localparam int LineW   = 7;
   localparam int RecLen  = 5;
   localparam int RecCntW = 3;

   localparam int DefBytesPerLine = 57;

   localparam logic [CfgW-1:0]  RstFrameWidth = 12'd640;
   localparam logic [CfgW-1:0]  RstWinLeft    = 12'd0;
   localparam logic [CfgW-1:0]  RstWinTop     = 12'd0;
   localparam logic [CfgW-1:0]  RstWinCols    = 12'd640;
   localparam logic [CfgW-1:0]  RstWinRows    = 12'd480;
   localparam logic [StepW-1:0] RstSampleStep = 8'd1;

   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharPad     = 8'h3D;

   // register indexes on the csr port
   typedef enum logic [CsrIdxW-1:0] {
      REG_FRAME_WIDTH = 3'd0,
      REG_WIN_LEFT    = 3'd1,
      REG_WIN_TOP     = 3'd2,
      REG_WIN_COLS    = 3'd3,
      REG_WIN_ROWS    = 3'd4,
      REG_SAMPLE_STEP = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [CfgW-1:0]  frame_width;
      logic [CfgW-1:0]  win_left;
      logic [CfgW-1:0]  win_top;
      logic [CfgW-1:0]  win_cols;
      logic [CfgW-1:0]  win_rows;
      logic [StepW-1:0] sample_step;
   } cfg_type;

   // window decision for the pixel in the input register
   typedef struct packed {
      logic keep;
      logic last;
   } pick_type;

   // characters caused by one pixel, first character at index 0
   typedef struct packed {
      logic [RecLen-1:0][7:0] chars;
      logic [RecCntW-1:0]     cnt;
      logic                   done;
   } rec_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] wide;
      wide = {2'b00, v};
      priority if (v < 6'd26) return 8'h41 + wide;
      else if (v < 6'd52) return 8'h61 + wide - 8'd26;
      else if (v < 6'd62) return 8'h30 + wide - 8'd52;
      else if (v == 6'd62) return 8'h2B;
      else return 8'h2F;
   endfunction

endpackage

// ===== rtl/wpb64_window.sv =====
// Frame position counters and window selection for the pixel stream.
// Depends on wpb64_pkg.
module wpb64_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               fs,
   input  wpb64_pkg::cfg_type cfg,
   output wpb64_pkg::pick_type pick
);
   import wpb64_pkg::*;

   logic [CfgW-1:0]  col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [StepW-1:0] col_phase_ff, col_phase_in, row_phase_ff, row_phase_in;
   logic [CfgW-1:0]  wci_ff, wci_in, wri_ff, wri_in;
   logic             finished_ff, finished_in;

   logic [CfgW-1:0]  cur_col_pos, cur_row_pos, cur_wci, cur_wri, col_pos_inc;
   logic [StepW-1:0] cur_col_phase, cur_row_phase, step;
   logic             active, row_in_win, col_in_win, row_sel, col_sel, at_last;

   function automatic logic [StepW-1:0] phase_next(input logic [StepW-1:0] p,
                                                   input logic [StepW-1:0] s);
      logic [StepW:0] sum;
      sum = {1'b0, p} + {{StepW{1'b0}}, 1'b1};
      return (sum >= {1'b0, s}) ? '0 : sum[StepW-1:0];
   endfunction

   // frame start handles its pixel from cleared counters
   always_comb begin
      cur_col_pos   = fs ? '0 : col_pos_ff;
      cur_row_pos   = fs ? '0 : row_pos_ff;
      cur_col_phase = fs ? '0 : col_phase_ff;
      cur_row_phase = fs ? '0 : row_phase_ff;
      cur_wci       = fs ? '0 : wci_ff;
      cur_wri       = fs ? '0 : wri_ff;
      active        = fs || !finished_ff;
      step          = (cfg.sample_step == '0) ? 8'd1 : cfg.sample_step;

      row_in_win = cur_row_pos >= cfg.win_top;
      col_in_win = cur_col_pos >= cfg.win_left;
      row_sel    = row_in_win && (cur_row_phase == '0) && (cur_wri < cfg.win_rows);
      col_sel    = col_in_win && (cur_col_phase == '0) && (cur_wci < cfg.win_cols);
      at_last    = (({1'b0, cur_wri} + 13'd1) == {1'b0, cfg.win_rows})
                && (({1'b0, cur_wci} + 13'd1) == {1'b0, cfg.win_cols});

      pick.keep = active && row_sel && col_sel;
      pick.last = active && row_sel && col_sel && at_last;
   end

   // counter advance for one pixel
   always_comb begin
      col_pos_in   = cur_col_pos;
      row_pos_in   = cur_row_pos;
      col_phase_in = cur_col_phase;
      row_phase_in = cur_row_phase;
      wci_in       = cur_wci;
      wri_in       = cur_wri;
      finished_in  = (fs ? 1'b0 : finished_ff) | pick.last;
      col_pos_inc  = cur_col_pos + 12'd1;

      if (col_in_win) begin
         wci_in       = cur_wci + {{(CfgW-1){1'b0}}, col_sel};
         col_phase_in = phase_next(cur_col_phase, step);
      end

      if (col_pos_inc == cfg.frame_width) begin
         wri_in = cur_wri + {{(CfgW-1){1'b0}}, row_sel};
         if (row_in_win) begin
            row_phase_in = phase_next(cur_row_phase, step);
         end
         if (cur_row_pos != '1) begin
            row_pos_in = cur_row_pos + 12'd1;
         end
         col_pos_in   = '0;
         col_phase_in = '0;
         wci_in       = '0;
      end else begin
         col_pos_in = col_pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         wci_ff       <= '0;
         wri_ff       <= '0;
         finished_ff  <= 1'b0;
      end else if (adv && active) begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         wci_ff       <= wci_in;
         wri_ff       <= wri_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// ===== rtl/wpb64_pack.sv =====
// Byte grouping, base64 symbol mapping, padding and line breaks.
// Depends on wpb64_pkg.
module wpb64_pack #(
   parameter int BYTES_PER_LINE = wpb64_pkg::DefBytesPerLine
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                fs,
   input  logic [7:0]          pixel,
   input  wpb64_pkg::pick_type pick,
   output wpb64_pkg::rec_type  rec_in
);
   import wpb64_pkg::*;

   localparam logic [LineW-1:0] LineBytes = LineW'(BYTES_PER_LINE);

   logic [15:0]      held_ff, held_in, cur_held;
   logic [1:0]       gfill_ff, gfill_in, cur_gfill;
   logic [LineW-1:0] lfill_ff, lfill_in, cur_lfill, lsum;
   logic [23:0]      grp;

   always_comb begin
      cur_held  = fs ? '0 : held_ff;
      cur_gfill = fs ? '0 : gfill_ff;
      cur_lfill = fs ? '0 : lfill_ff;
      held_in   = cur_held;
      gfill_in  = cur_gfill;
      lfill_in  = cur_lfill;
      lsum      = cur_lfill + 7'd3;
      grp       = {cur_held, pixel};
      rec_in    = '0;

      if (pick.keep) begin
         if (cur_gfill == 2'd2) begin
            // full group of three bytes
            rec_in.chars[0] = b64_char(grp[23:18]);
            rec_in.chars[1] = b64_char(grp[17:12]);
            rec_in.chars[2] = b64_char(grp[11:6]);
            rec_in.chars[3] = b64_char(grp[5:0]);
            held_in  = '0;
            gfill_in = '0;
            if (pick.last) begin
               rec_in.chars[4] = CharNewline;
               rec_in.cnt      = 3'd5;
               rec_in.done     = 1'b1;
               lfill_in        = '0;
            end else if (lsum >= LineBytes) begin
               rec_in.chars[4] = CharNewline;
               rec_in.cnt      = 3'd5;
               lfill_in        = '0;
            end else begin
               rec_in.cnt = 3'd4;
               lfill_in   = lsum;
            end
         end else if (pick.last) begin
            // partial final group, padded
            grp = (cur_gfill == 2'd1) ? {cur_held[7:0], pixel, 8'h00}
                                      : {pixel, 16'h0000};
            rec_in.chars[0] = b64_char(grp[23:18]);
            rec_in.chars[1] = b64_char(grp[17:12]);
            rec_in.chars[2] = (cur_gfill == 2'd1) ? b64_char(grp[11:6]) : CharPad;
            rec_in.chars[3] = CharPad;
            rec_in.chars[4] = CharNewline;
            rec_in.cnt      = 3'd5;
            rec_in.done     = 1'b1;
            held_in         = '0;
            gfill_in        = '0;
            lfill_in        = '0;
         end else begin
            held_in  = {cur_held[7:0], pixel};
            gfill_in = cur_gfill + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         gfill_ff <= '0;
         lfill_ff <= '0;
      end else if (adv) begin
         held_ff  <= held_in;
         gfill_ff <= gfill_in;
         lfill_ff <= lfill_in;
      end
   end

endmodule

// ===== rtl/windowed_pixel_base64_encoder.sv =====
// Top level of the windowed pixel base64 encoder: csr registers, input
// register, character record and character output. Uses wpb64_pkg,
// wpb64_window and wpb64_pack.
//
//   channel | ports                                   | transfer when
//   --------+-----------------------------------------+----------------------
//   req     | req_pixel, req_frame_start              | req_valid & req_ready
//   rsp     | rsp_out_char, rsp_frame_done            | rsp_valid & rsp_ready
//   csr     | csr_index, csr_wdata                    | csr_we
//
// A pixel waits in the input register, then its characters (zero to five)
// leave the record register one per cycle while rsp_ready is high. Pixels
// that give no characters pass at one per cycle while the record is free;
// in the window, the drain of the record register sets the rate.
// Reset is synchronous and restores the default window. A stalled rsp side
// holds the record; the input register still takes one more pixel.
module windowed_pixel_base64_encoder #(
   parameter int BYTES_PER_LINE = wpb64_pkg::DefBytesPerLine
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_pixel,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_char,
   output logic                            rsp_frame_done,
   input  logic                            csr_we,
   input  logic [wpb64_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [wpb64_pkg::CfgW-1:0]      csr_wdata
);
   import wpb64_pkg::*;

   cfg_type              cfg_ff;
   logic                 a_valid_ff;
   logic [7:0]           a_pixel_ff;
   logic                 a_fs_ff;
   rec_type              rec_ff, rec_in;
   logic [RecCntW-1:0]   idx_ff;
   logic                 rec_busy, take, last_take, rec_free, adv;
   pick_type             pick;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= RstFrameWidth;
         cfg_ff.win_left    <= RstWinLeft;
         cfg_ff.win_top     <= RstWinTop;
         cfg_ff.win_cols    <= RstWinCols;
         cfg_ff.win_rows    <= RstWinRows;
         cfg_ff.sample_step <= RstSampleStep;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH: cfg_ff.frame_width <= csr_wdata;
            REG_WIN_LEFT:    cfg_ff.win_left    <= csr_wdata;
            REG_WIN_TOP:     cfg_ff.win_top     <= csr_wdata;
            REG_WIN_COLS:    cfg_ff.win_cols    <= csr_wdata;
            REG_WIN_ROWS:    cfg_ff.win_rows    <= csr_wdata;
            REG_SAMPLE_STEP: cfg_ff.sample_step <= csr_wdata[StepW-1:0];
            default: ;
         endcase
      end
   end

   // handshake and record control
   always_comb begin
      rec_busy  = idx_ff != rec_ff.cnt;
      take      = rec_busy && rsp_ready;
      last_take = take && (idx_ff == (rec_ff.cnt - 3'd1));
      rec_free  = !rec_busy || last_take;
      adv       = a_valid_ff && rec_free;
      req_ready = !a_valid_ff || rec_free;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         a_pixel_ff <= req_pixel;
         a_fs_ff    <= req_frame_start;
      end
   end

   wpb64_window u_window (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .fs    (a_fs_ff),
      .cfg   (cfg_ff),
      .pick  (pick)
   );

   wpb64_pack #(
      .BYTES_PER_LINE (BYTES_PER_LINE)
   ) u_pack (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .fs     (a_fs_ff),
      .pixel  (a_pixel_ff),
      .pick   (pick),
      .rec_in (rec_in)
   );

   // record register and read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
         idx_ff <= '0;
      end else if (adv) begin
         rec_ff <= rec_in;
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // character output
   always_comb begin
      rsp_valid      = rec_busy;
      rsp_out_char   = rec_ff.chars[idx_ff];
      rsp_frame_done = rec_ff.done && (idx_ff == (rec_ff.cnt - 3'd1));
   end

endmodule

// ===== rtl/wpb64_checker.sv =====
// Port-level checks of the windowed base64 encoder, bound to the top level.
// Depends on wpb64_pkg and windowed_pixel_base64_encoder_defines.svh.
`include "windowed_pixel_base64_encoder_defines.svh"

module wpb64_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_frame_done
);
   import wpb64_pkg::*;

   // stalled character holds
   `WPB64_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_char) && $stable(rsp_frame_done))

   // end of frame is marked only on the closing newline
   `WPB64_ASSERT_IMPL(a_done_newline, clock, reset, rsp_valid && rsp_frame_done, rsp_out_char == CharNewline)

   // with nothing left to send the input side is open
   `WPB64_ASSERT_IMPL(a_ready_drained, clock, reset, !rsp_valid, req_ready)

   // reset empties the block
   `WPB64_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind windowed_pixel_base64_encoder wpb64_checker u_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for windowed_pixel_base64_encoder: pixel frames in, base64 text out.
// A built-in window/packing predictor checks every character. Depends on wpb64_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
   import wpb64_pkg::*;

   localparam int LINE_BYTES  = 57;
   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PCT    = 17;
   localparam string B64_SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] pix;
      logic       fs;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       done;
   } enc_char_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [7:0]          req_pixel       = 8'h00;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [7:0]          rsp_out_char;
   logic                rsp_frame_done;
   logic                csr_we          = 1'b0;
   logic [CsrIdxW-1:0]  csr_index       = '0;
   logic [CfgW-1:0]     csr_wdata       = '0;

   // pixels waiting for the driver, characters waiting for the monitor
   pixel_item_type pixel_backlog[$];
   enc_char_type   expected_chars[$];

   // predictor copy of the registers and of the scan state
   cfg_type     win_cfg;
   logic [11:0] scan_col  = '0;
   logic [11:0] scan_row  = '0;
   int          col_pitch_pos = 0;
   int          row_pitch_pos = 0;
   int          cols_taken    = 0;
   int          rows_taken    = 0;
   logic [15:0] pend_bytes    = '0;
   int          pend_count    = 0;
   int          line_bytes    = 0;
   bit          frame_closed  = 1'b0;

   int cycle_count    = 0;
   int err_count      = 0;
   int pixels_sent    = 0;
   int chars_checked  = 0;
   int frames_closed  = 0;
   int settings_used  = 0;
   int hold_left      = 0;
   int holds_done     = 0;
   int next_hold_at   = 100;
   logic calm_stretch;

   assign calm_stretch = (cycle_count >= 700) && (cycle_count < 1200);

   windowed_pixel_base64_encoder #(
      .BYTES_PER_LINE(LINE_BYTES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_frame_start(req_frame_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic push_char(input logic [7:0] ch, input logic done);
      expected_chars.push_back('{ch: ch, done: done});
   endtask

   // four symbols for one group, '=' in place of missing bytes
   task automatic push_group(input logic [23:0] grp, input int nbytes);
      push_char(B64_SYMBOLS[grp[23:18]], 1'b0);
      push_char(B64_SYMBOLS[grp[17:12]], 1'b0);
      push_char((nbytes >= 2) ? B64_SYMBOLS[grp[11:6]] : CharPad, 1'b0);
      push_char((nbytes >= 3) ? B64_SYMBOLS[grp[5:0]] : CharPad, 1'b0);
   endtask

   task automatic predict_pixel(input logic [7:0] pix, input logic fs);
      int          pitch;
      bit          row_take;
      bit          col_take;
      bit          closing;
      logic [11:0] col_next;
      logic [23:0] grp;
      pitch = (win_cfg.sample_step == 8'd0) ? 1 : int'(win_cfg.sample_step);
      // frame start clears everything; a closed frame swallows pixels
      if (fs) begin
         scan_col = '0;
         scan_row = '0;
         col_pitch_pos = 0;
         row_pitch_pos = 0;
         cols_taken = 0;
         rows_taken = 0;
         pend_bytes = '0;
         pend_count = 0;
         line_bytes = 0;
         frame_closed = 1'b0;
      end else if (frame_closed) begin
         return;
      end
      row_take = (scan_row >= win_cfg.win_top) && (row_pitch_pos == 0) &&
                 (rows_taken < int'(win_cfg.win_rows));
      col_take = (scan_col >= win_cfg.win_left) && (col_pitch_pos == 0) &&
                 (cols_taken < int'(win_cfg.win_cols));
      closing  = (rows_taken + 1 == int'(win_cfg.win_rows)) &&
                 (cols_taken + 1 == int'(win_cfg.win_cols));
      // byte packing and line breaks
      if (row_take && col_take) begin
         if (pend_count >= 2) begin
            grp = {pend_bytes, pix};
            push_group(grp, 3);
            pend_count = 0;
            pend_bytes = '0;
            line_bytes += 3;
            if (closing) begin
               push_char(CharNewline, 1'b1);
               line_bytes = 0;
            end else if (line_bytes >= LINE_BYTES) begin
               push_char(CharNewline, 1'b0);
               line_bytes = 0;
            end
         end else if (closing) begin
            grp = (pend_count == 1) ? {pend_bytes[7:0], pix, 8'h00} : {pix, 16'h0000};
            push_group(grp, pend_count + 1);
            push_char(CharNewline, 1'b1);
            pend_count = 0;
            pend_bytes = '0;
            line_bytes = 0;
         end else begin
            pend_bytes = {pend_bytes[7:0], pix};
            pend_count++;
         end
         if (closing) frame_closed = 1'b1;
      end
      // column position and pitch
      if (scan_col >= win_cfg.win_left) begin
         if (col_take) cols_taken++;
         col_pitch_pos = (col_pitch_pos + 1 >= pitch) ? 0 : col_pitch_pos + 1;
      end
      // end of row; a zero width wraps at 4096
      col_next = scan_col + 12'd1;
      if (col_next == win_cfg.frame_width) begin
         if (row_take) rows_taken++;
         if (scan_row >= win_cfg.win_top)
            row_pitch_pos = (row_pitch_pos + 1 >= pitch) ? 0 : row_pitch_pos + 1;
         if (scan_row != 12'hFFF) scan_row = scan_row + 12'd1;
         scan_col = '0;
         col_pitch_pos = 0;
         cols_taken = 0;
      end else begin
         scan_col = col_next;
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_req
      pixel_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pixel(req_pixel, req_frame_start);
            pixels_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_backlog.size() != 0 &&
                (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = pixel_backlog.pop_front();
               req_valid       <= 1'b1;
               req_pixel       <= nxt.pix;
               req_frame_start <= nxt.fs;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic note_mismatch(input logic [7:0] exp_ch, input logic exp_done,
                                input bit none_waiting);
      err_count++;
      if (err_count <= 10) begin
         if (none_waiting)
            $display("char %0d: nothing expected, got %02h done=%0b",
                     chars_checked, rsp_out_char, rsp_frame_done);
         else
            $display("char %0d: expected %02h done=%0b, got %02h done=%0b",
                     chars_checked, exp_ch, exp_done, rsp_out_char, rsp_frame_done);
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      enc_char_type exp;
      logic         ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         // compare each transfer with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               note_mismatch(8'h00, 1'b0, 1'b1);
            end else begin
               exp = expected_chars.pop_front();
               if (rsp_out_char !== exp.ch || rsp_frame_done !== exp.done)
                  note_mismatch(exp.ch, exp.done, 1'b0);
               if (exp.done) frames_closed++;
            end
            chars_checked++;
         end
         // long hold-off while the sender keeps offering, else random stalls
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (holds_done < 2 && pixel_backlog.size() > 40 &&
                      cycle_count > next_hold_at) begin
            hold_left = 400;
            holds_done++;
            next_hold_at = cycle_count + 20000;
            ready_next = 1'b0;
         end else begin
            ready_next = calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
         end
         rsp_ready <= ready_next;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(input csr_reg_type idx, input logic [11:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_FRAME_WIDTH: win_cfg.frame_width = val;
         REG_WIN_LEFT:    win_cfg.win_left    = val;
         REG_WIN_TOP:     win_cfg.win_top     = val;
         REG_WIN_COLS:    win_cfg.win_cols    = val;
         REG_WIN_ROWS:    win_cfg.win_rows    = val;
         REG_SAMPLE_STEP: win_cfg.sample_step = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // block drained: nothing queued, nothing outstanding, plus pipeline slack
   task automatic wait_idle();
      while (pixel_backlog.size() != 0 || req_valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // pixels up to and including the last window pixel; two rows for an empty window
   function automatic int frame_len();
      int fw;
      int pitch;
      fw    = (win_cfg.frame_width == 0) ? 4096 : int'(win_cfg.frame_width);
      pitch = (win_cfg.sample_step == 0) ? 1 : int'(win_cfg.sample_step);
      if (win_cfg.win_cols == 0 || win_cfg.win_rows == 0) return 2 * fw;
      return (int'(win_cfg.win_top) + (int'(win_cfg.win_rows) - 1) * pitch) * fw +
             int'(win_cfg.win_left) + (int'(win_cfg.win_cols) - 1) * pitch + 1;
   endfunction

   task automatic push_pixel(input logic [7:0] pix, input logic fs);
      pixel_backlog.push_back('{pix: pix, fs: fs});
   endtask

   // new window setting, then whole frames (cut at cap) with a few stray pixels after
   task automatic run_window(input int fw, input int left, input int top, input int cols,
                             input int rows, input logic [11:0] pitch, input int frames,
                             input int cap, output int pushed);
      int len;
      wait_idle();
      write_reg(REG_FRAME_WIDTH, fw[11:0]);
      write_reg(REG_WIN_LEFT,    left[11:0]);
      write_reg(REG_WIN_TOP,     top[11:0]);
      write_reg(REG_WIN_COLS,    cols[11:0]);
      write_reg(REG_WIN_ROWS,    rows[11:0]);
      write_reg(REG_SAMPLE_STEP, pitch);
      settings_used++;
      pushed = 0;
      repeat (frames) begin
         len = frame_len();
         if (len > cap) len = cap;
         for (int i = 0; i < len; i++) push_pixel(8'($urandom_range(0, 255)), i == 0);
         repeat ($urandom_range(0, 3)) push_pixel(8'($urandom_range(0, 255)), 1'b0);
         pushed += len;
      end
   endtask

   initial begin : stimulus
      int fw;
      int left;
      int top;
      int cols;
      int rows;
      int pitch;
      int eff;
      int max_cols;
      int cap;
      int pushed;
      int random_items;
      win_cfg = '{frame_width: RstFrameWidth, win_left: RstWinLeft, win_top: RstWinTop,
                  win_cols: RstWinCols, win_rows: RstWinRows, sample_step: RstSampleStep};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset window: pixels before any frame start, then a start mid-group
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h80, 1'b0);
      push_pixel(8'hFB, 1'b1);
      push_pixel(8'hEF, 1'b0);
      push_pixel(8'hBE, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'h04, 1'b0);
      push_pixel(8'h10, 1'b0);
      push_pixel(8'h83, 1'b0);

      // small windows: full groups, one and two byte tails, line breaks
      run_window(5, 1, 1, 3, 2, 12'd1, 2, 100000, pushed);
      run_window(4, 1, 0, 1, 1, 12'd1, 2, 100000, pushed);
      run_window(6, 0, 1, 5, 1, 12'd1, 1, 100000, pushed);
      run_window(19, 0, 0, 19, 3, 12'd1, 1, 100000, pushed);
      run_window(20, 0, 0, 20, 4, 12'd1, 1, 100000, pushed);
      // empty windows, zero step, window hanging past the row end
      run_window(6, 0, 0, 0, 2, 12'd1, 1, 100000, pushed);
      run_window(6, 0, 0, 2, 0, 12'd1, 1, 100000, pushed);
      run_window(6, 1, 1, 3, 2, 12'd0, 2, 100000, pushed);
      run_window(4, 2, 0, 3, 1, 12'd1, 1, 24, pushed);
      // widest pitch, with junk in the upper data bits; first pixels only
      run_window(3, 0, 0, 1, 2, 12'hAFF, 1, 20, pushed);
      // register extremes: 4096-wide rows, last column and row, full-size window;
      // first pixels of each only
      run_window(0, 4095, 0, 1, 1, 12'd1, 1, 8, pushed);
      run_window(1, 0, 4095, 1, 2, 12'd1, 1, 8, pushed);
      run_window(4095, 0, 0, 4095, 1, 12'd1, 1, 8, pushed);
      run_window(1, 0, 0, 1, 4095, 12'd1, 1, 8, pushed);

      // random windows, mostly complete frames, some cut short or broken
      random_items = 0;
      while (random_items < 40) begin
         if ($urandom_range(0, 7) == 0) begin
            pushed = $urandom_range(5, 20);
            repeat (pushed)
               push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            fw    = $urandom_range(1, 12);
            pitch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3);
            eff   = (pitch == 0) ? 1 : pitch;
            left  = $urandom_range(0, fw - 1);
            max_cols = (fw - 1 - left) / eff + 1;
            cols  = $urandom_range(1, max_cols);
            top   = $urandom_range(0, 3);
            rows  = $urandom_range(1, 6);
            cap   = 100000;
            case ($urandom_range(0, 11))
               0: cols = max_cols + 1;
               1: cols = 0;
               2: cap = $urandom_range(1, 30);
               default: ;
            endcase
            if (cols == max_cols + 1 || cols == 0) cap = $urandom_range(5, 40);
            run_window(fw, left, top, cols, rows, pitch[11:0], $urandom_range(1, 2), cap,
                       pushed);
         end
         random_items += pushed;
      end

      // drain, then give the pipeline time to flush anything unexpected
      while (pixel_backlog.size() != 0 || req_valid) @(posedge clock);
      for (int n = 0; n < 20000 && expected_chars.size() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_chars.size() != 0) begin
         err_count += expected_chars.size();
         $display("%0d expected characters never arrived", expected_chars.size());
      end

      $display("covered %0d pixel transfers and %0d checked characters, %0d frames closed",
               pixels_sent, chars_checked, frames_closed);
      $display("%0d window settings incl. register extremes, %0d long output stalls",
               settings_used, holds_done);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", err_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wpb64_pkg.sv
rtl/wpb64_window.sv
rtl/wpb64_pack.sv
rtl/windowed_pixel_base64_encoder.sv
rtl/wpb64_checker.sv
bench/tb.sv
